// ----- rtl/acs_pkg.sv -----
// Package: shared types, codes and constants for the accumulator step unit.
`timescale 1ns / 1ps
`default_nettype none
package acs_pkg;
  localparam int MemDepthDefault = 256;
  localparam int DataW = 8;
  localparam int WordW = 12;
  localparam int PcW = 9;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 9;
  localparam logic [PcW-1:0] PcTop = 9'd256;

  localparam logic [1:0] FuncWrite   = 2'd0;
  localparam logic [1:0] FuncRestart = 2'd1;
  localparam logic [1:0] FuncExec    = 2'd2;

  localparam logic [1:0] StRun  = 2'd0;
  localparam logic [1:0] StHlt  = 2'd1;
  localparam logic [1:0] StEnd  = 2'd2;
  localparam logic [1:0] StDivZ = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgStart = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgEnd   = 1'd1;

  localparam logic [3:0] OpGrp = 4'd0, OpLda = 4'd1, OpSta = 4'd2, OpLdi = 4'd3,
    OpMab = 4'd4, OpMba = 4'd5, OpAdd = 4'd6, OpSub = 4'd7, OpMul = 4'd8,
    OpDiv = 4'd9, OpLog = 4'd10, OpInd = 4'd11, OpJmp = 4'd12, OpCal = 4'd13,
    OpRet = 4'd14, OpHlt = 4'd15;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_DECODE, S_OPER, S_DIV, S_MUL, S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  mem_addr;
    logic [11:0] mem_word;
  } in_item_t;

  typedef struct packed {
    logic [7:0] acc_value;
    logic [7:0] b_value;
    logic       carry_flag;
    logic       zero_flag;
    logic [8:0] next_pc;
    logic [1:0] run_status;
    logic       stored;
    logic [7:0] store_addr;
  } out_item_t;

  typedef struct packed {
    logic       start;
    logic [7:0] dividend;
    logic [7:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] quot;
    logic [7:0] rem;
  } div_rsp_t;
endpackage
`default_nettype wire

// ----- rtl/acs_divider.sv -----
// Iterative restoring 8-bit divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module acs_divider import acs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  logic [3:0] cnt_r;
  logic       busy_r, done_r;
  logic [7:0] q_r, d_r;
  logic [8:0] rem_r;
  logic [8:0] trial;

  assign trial = {rem_r[7:0], q_r[7]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 4'd8;
        q_r    <= req.dividend;
        d_r    <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        if (trial >= {1'b0, d_r}) begin
          rem_r <= trial - {1'b0, d_r};
          q_r   <= {q_r[6:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r   <= {q_r[6:0], 1'b0};
        end
        cnt_r <= cnt_r - 4'd1;
        if (cnt_r == 4'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r[7:0];
endmodule
`default_nettype wire

// ----- rtl/accumulator_cpu_step_unit.sv -----
// Top level: accumulator machine step unit with program memory and sequencer.
//   channel | ports             | direction
//   input   | in_valid/in_stall | item in: func, mem_addr, mem_word
//   output  | out_valid/out_stall | result item
//   config  | cfg_we/idx/data   | register write
// A write or restart item goes through fetch and done; an execute item on a
// running machine goes through decode and operand too, MUL a multiply state,
// and DIV waits in a divide state on the 8-bit iterative divider. After reset
// a clearing pass sweeps the program memory before the first item is taken.
// The result sits in an output register; one item is in flight at a time.
`timescale 1ns / 1ps
`default_nettype none
module accumulator_cpu_step_unit import acs_pkg::*; #(
  parameter int MEM_DEPTH = MemDepthDefault
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire in_item_t            in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output out_item_t                out_data,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_idx,
  input  wire logic [CfgDataW-1:0] cfg_data
);
  localparam int AW = $clog2(MEM_DEPTH);

  logic [WordW-1:0] mem [MEM_DEPTH];
  logic [WordW-1:0] rd_data_r;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic             rd_en, wr_en;
  logic [WordW-1:0] wr_data;

  logic [AW:0] clr_cnt_r;
  logic        clr_busy_r;

  state_t state_r, state_nxt;
  in_item_t item_r, item_nxt;
  logic [7:0] acc_r, acc_nxt, b_r, b_nxt;
  logic carry_r, carry_nxt, zero_r, zero_nxt;
  logic [8:0] pc_r, pc_nxt, ret_r, ret_nxt;
  logic [1:0] halt_r, halt_nxt;
  logic [7:0] start_r;
  logic [8:0] end_r;
  logic [11:0] ir_r, ir_nxt;
  logic [15:0] prod_r, prod_nxt;
  out_item_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;
  logic st_nxt;
  logic [7:0] sa_nxt;
  div_req_t dreq;
  div_rsp_t drsp;

  logic [8:0] lim;
  logic [3:0] op;
  logic [7:0] opd;
  logic [8:0] inc9, skip9, tsum;
  logic [7:0] acc_w;

  acs_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
      start_r    <= '0;
      end_r      <= PcTop;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == (AW+1)'(MEM_DEPTH - 1)) clr_busy_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          CfgStart: start_r <= cfg_data[7:0];
          CfgEnd:   end_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      acc_r <= '0; b_r <= '0; carry_r <= 1'b0; zero_r <= 1'b0;
      pc_r <= '0; ret_r <= '0; halt_r <= StRun;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      acc_r <= acc_nxt; b_r <= b_nxt; carry_r <= carry_nxt; zero_r <= zero_nxt;
      pc_r <= pc_nxt; ret_r <= ret_nxt; halt_r <= halt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    ir_r   <= ir_nxt;
    prod_r <= prod_nxt;
    out_r  <= out_nxt;
  end

  assign lim   = (end_r > PcTop) ? PcTop : end_r;
  assign op    = ir_r[11:8];
  assign opd   = ir_r[7:0];
  assign inc9  = pc_r + 9'd1;
  assign skip9 = (pc_r + 9'd2 > PcTop) ? PcTop : pc_r + 9'd2;

  always_comb begin
    state_nxt = state_r;
    item_nxt = item_r; ir_nxt = ir_r; prod_nxt = prod_r;
    acc_nxt = acc_r; b_nxt = b_r; carry_nxt = carry_r; zero_nxt = zero_r;
    pc_nxt = pc_r; ret_nxt = ret_r; halt_nxt = halt_r;
    out_nxt = out_r; out_valid_nxt = out_valid_r;
    rd_en = 1'b0; rd_addr = '0;
    wr_en = 1'b0; wr_addr = '0; wr_data = '0;
    dreq = '0;
    st_nxt = 1'b0; sa_nxt = '0;
    tsum = '0; acc_w = acc_r;
    in_stall = 1'b1;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (clr_busy_r) begin
      wr_en = 1'b1;
      wr_addr = clr_cnt_r[AW-1:0];
    end
    unique case (state_r)
      S_IDLE: begin
        in_stall = clr_busy_r || (out_valid_r && out_stall);
        if (in_valid && !in_stall) begin
          item_nxt = in_data;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        state_nxt = S_DONE;
        if (item_r.func == FuncWrite) begin
          wr_en = 1'b1;
          wr_addr = AW'(item_r.mem_addr % MEM_DEPTH);
          wr_data = item_r.mem_word;
        end else if (item_r.func == FuncRestart) begin
          pc_nxt = {1'b0, start_r};
          halt_nxt = ({1'b0, start_r} >= lim) ? StEnd : StRun;
        end else if (item_r.func == FuncExec && halt_r == StRun) begin
          if (pc_r >= lim) halt_nxt = StEnd;
          else begin
            rd_en = 1'b1;
            rd_addr = AW'(pc_r % MEM_DEPTH);
            state_nxt = S_DECODE;
          end
        end
      end
      S_DECODE: begin
        ir_nxt = rd_data_r;
        rd_en = 1'b1;
        rd_addr = (rd_data_r[11:8] == OpInd) ? AW'(b_r % MEM_DEPTH)
                                             : AW'(rd_data_r[7:0] % MEM_DEPTH);
        state_nxt = S_OPER;
      end
      S_OPER: begin
        pc_nxt = inc9;
        state_nxt = S_DONE;
        case (op)
          OpGrp: begin
            case (opd)
              8'd0: acc_nxt = '0;
              8'd1: carry_nxt = 1'b0;
              8'd2: zero_nxt = 1'b0;
              8'd3: acc_nxt = ~acc_r;
              8'd4: carry_nxt = ~carry_r;
              8'd5: zero_nxt = ~zero_r;
              8'd6: begin
                tsum = {1'b0, acc_r} + 9'd1;
                carry_nxt = tsum[8]; acc_nxt = tsum[7:0];
                zero_nxt = (tsum[7:0] == 8'd0);
              end
              8'd7: begin
                carry_nxt = (acc_r == 8'd0); acc_nxt = acc_r - 8'd1;
                zero_nxt = (acc_r == 8'd1);
              end
              8'd8:  if (carry_r) pc_nxt = skip9;
              8'd9:  if (!carry_r) pc_nxt = skip9;
              8'd10: if (zero_r) pc_nxt = skip9;
              8'd11: if (!zero_r) pc_nxt = skip9;
              8'd12: begin
                acc_w = {carry_r, acc_r[7:1]};
                carry_nxt = acc_r[0]; acc_nxt = acc_w; zero_nxt = (acc_w == 8'd0);
              end
              8'd13: begin
                acc_w = {acc_r[6:0], carry_r};
                carry_nxt = acc_r[7]; acc_nxt = acc_w; zero_nxt = (acc_w == 8'd0);
              end
              default: ;
            endcase
          end
          OpLda: acc_nxt = rd_data_r[7:0];
          OpSta: begin
            wr_en = 1'b1; wr_addr = AW'(opd % MEM_DEPTH); wr_data = {4'd0, acc_r};
            st_nxt = 1'b1; sa_nxt = 8'(opd % MEM_DEPTH);
          end
          OpLdi: acc_nxt = opd;
          OpMab: b_nxt = acc_r;
          OpMba: acc_nxt = b_r;
          OpAdd: begin
            tsum = {1'b0, acc_r} + {1'b0, b_r};
            carry_nxt = tsum[8]; acc_nxt = tsum[7:0];
            zero_nxt = (tsum[7:0] == 8'd0);
          end
          OpSub: begin
            acc_w = acc_r - b_r;
            carry_nxt = (acc_r < b_r); acc_nxt = acc_w; zero_nxt = (acc_w == 8'd0);
          end
          OpMul: begin
            prod_nxt = acc_r * b_r;
            pc_nxt = pc_r;
            state_nxt = S_MUL;
          end
          OpDiv: begin
            if (b_r == 8'd0) begin
              halt_nxt = StDivZ; pc_nxt = pc_r;
            end else begin
              dreq.start = 1'b1; dreq.dividend = acc_r; dreq.divisor = b_r;
              pc_nxt = pc_r;
              state_nxt = S_DIV;
            end
          end
          OpLog: begin
            if (opd == 8'd0) begin
              acc_w = acc_r & b_r; acc_nxt = acc_w; zero_nxt = (acc_w == 8'd0);
            end else if (opd == 8'd1) begin
              acc_w = acc_r | b_r; acc_nxt = acc_w; zero_nxt = (acc_w == 8'd0);
            end
          end
          OpInd: begin
            if (opd == 8'd0) acc_nxt = rd_data_r[7:0];
            else if (opd == 8'd1) begin
              wr_en = 1'b1; wr_addr = AW'(b_r % MEM_DEPTH); wr_data = {4'd0, acc_r};
              st_nxt = 1'b1; sa_nxt = 8'(b_r % MEM_DEPTH);
            end
          end
          OpJmp: pc_nxt = {1'b0, opd};
          OpCal: begin ret_nxt = inc9; pc_nxt = {1'b0, opd}; end
          OpRet: pc_nxt = ret_r;
          OpHlt: begin halt_nxt = StHlt; pc_nxt = pc_r; end
          default: ;
        endcase
        if (state_nxt == S_DONE && halt_nxt == StRun && pc_nxt >= lim)
          halt_nxt = StEnd;
      end
      S_MUL: begin
        if (prod_r > 16'd255) begin
          b_nxt = prod_r[15:8]; carry_nxt = 1'b1;
        end else carry_nxt = 1'b0;
        acc_nxt = prod_r[7:0];
        zero_nxt = (prod_r[7:0] == 8'd0);
        pc_nxt = inc9;
        if (inc9 >= lim) halt_nxt = StEnd;
        state_nxt = S_DONE;
      end
      S_DIV: begin
        if (drsp.done) begin
          acc_nxt = drsp.quot; b_nxt = drsp.rem;
          zero_nxt = (drsp.quot == 8'd0);
          pc_nxt = inc9;
          if (inc9 >= lim) halt_nxt = StEnd;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if ((state_r == S_FETCH && state_nxt == S_DONE) || state_r == S_OPER ||
        state_r == S_MUL || state_r == S_DIV) begin
      if (state_nxt == S_DONE) begin
        out_valid_nxt = 1'b1;
        out_nxt.acc_value = acc_nxt;
        out_nxt.b_value = b_nxt;
        out_nxt.carry_flag = carry_nxt;
        out_nxt.zero_flag = zero_nxt;
        out_nxt.next_pc = pc_nxt;
        out_nxt.run_status = halt_nxt;
        out_nxt.stored = st_nxt;
        out_nxt.store_addr = sa_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("item accepted while busy");
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> in_stall) else $error("item accepted during memory clear");
  a_store_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.stored) |-> (out_data.store_addr == 8'd0))
    else $error("store address without store");
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= PcTop) else $error("program counter out of range");
endmodule
`default_nettype wire
